/* src/mstk_pkg.sv */
// Shared types and fixed field widths of the Kruskal spanning tree core.
package mstk_pkg;

	localparam int unsigned SRC_W      = 5;
	localparam int unsigned WT_W       = 16;
	localparam int unsigned VCFG_W     = 6;
	localparam logic [VCFG_W-1:0] VCFG_RESET = 6'd32;

	typedef struct packed {
		logic [SRC_W-1:0] edge_src;
		logic [SRC_W-1:0] edge_dst;
		logic [WT_W-1:0]  edge_weight;
		logic             edge_last;
	} edge_t;

	typedef struct packed {
		logic [SRC_W-1:0] tree_src;
		logic [SRC_W-1:0] tree_dst;
		logic [WT_W-1:0]  tree_weight;
		logic             tree_valid;
		logic             tree_last;
	} tree_t;

	// Classified edge handed from the front end to the engine.
	typedef struct packed {
		edge_t item;
		logic  keep;
	} cmd_t;

endpackage

/* src/mstk_ram.sv */
// Generic single-port-write RAM with registered read.
module mstk_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* src/mstk_fifo.sv */
// Small register queue used between the core's stages.
module mstk_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rdata   = slot_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			// wrap pointers at the depth
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

/* src/mstk_front.sv */
// Front end: range-checks arriving edges and queues them for the engine.
module mstk_front
	import mstk_pkg::*;
#(
	parameter int unsigned VCW = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  edge_t          edge_item,
	output logic           full,
	input  logic [VCW-1:0] vcnt,
	output cmd_t           cmd,
	output logic           cmd_valid,
	input  logic           cmd_pop
);
	localparam int unsigned CW = VCW + SRC_W;

	cmd_t cin;
	logic [$bits(cmd_t)-1:0] cout;
	logic cempty;

	// flag edges that touch a vertex outside the active range; the engine drops them
	always_comb begin
		cin.item = edge_item;
		cin.keep = (CW'(edge_item.edge_src) < CW'(vcnt)) &&
		           (CW'(edge_item.edge_dst) < CW'(vcnt));
	end

	mstk_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_q (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(cin), .full(full),
		.pop(cmd_pop), .rdata(cout), .empty(cempty)
	);

	assign cmd       = cmd_t'(cout);
	assign cmd_valid = !cempty;
endmodule

/* src/mstk_back.sv */
// Engine: edge store, minimum-edge scan, union-find and result emission.
module mstk_back
	import mstk_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = 32,
	parameter int unsigned MAX_EDGES    = 256,
	parameter int unsigned WEIGHT_BITS  = 16,
	parameter int unsigned VCW          = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [VCW-1:0] vcnt,
	input  cmd_t           cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	output logic           out_push,
	output tree_t          out_data,
	input  logic           out_full
);
	localparam int unsigned IDXW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned CNTW = $clog2(MAX_EDGES + 1);
	localparam int unsigned VW   = $clog2(MAX_VERTICES);
	localparam int unsigned PW   = VW + 1;
	localparam int unsigned RW   = 2 * SRC_W + WEIGHT_BITS;
	localparam int unsigned CW   = VCW + SRC_W;

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_FINDA = 6'b000100,
		ST_FINDB = 6'b001000,
		ST_JOIN  = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	state_t st_q;

	logic [CNTW-1:0]        total_q, iss_q;
	logic                   vld_s1;
	logic [IDXW-1:0]        idx_s1;
	logic                   best_any_q, prev_any_q;
	logic [WEIGHT_BITS-1:0] best_w_q, prev_w_q;
	logic [IDXW-1:0]        best_i_q, prev_i_q;
	logic [SRC_W-1:0]       best_src_q, best_dst_q;
	logic                   pend_v_q;
	logic [SRC_W-1:0]       pend_src_q, pend_dst_q;
	logic [WEIGHT_BITS-1:0] pend_w_q;
	logic [VCW-1:0]         found_q;
	logic [PW-1:0]          parent_q [MAX_VERTICES];
	logic [VW-1:0]          cur_q, ra_q, rb_q;
	logic [PW-1:0]          ra_val_q, rb_val_q;

	logic                   we;
	logic [RW-1:0]          wdata, rdata;
	logic [SRC_W-1:0]       rd_src, rd_dst;
	logic [WEIGHT_BITS-1:0] rd_w;
	logic                   gt_prev, lt_best, cand, pass_done, best_in_range;
	logic [PW-1:0]          p_cur, sum_val;
	logic [VCW-1:0]         need;
	logic                   join_go, flush_go;

	assign cmd_pop = (st_q == ST_LOAD) && cmd_valid;
	assign we      = cmd_pop && cmd.keep && (total_q < CNTW'(MAX_EDGES));
	assign wdata   = {cmd.item.edge_src, cmd.item.edge_dst,
	                  WEIGHT_BITS'(cmd.item.edge_weight)};

	mstk_ram #(.WIDTH(RW), .DEPTH(MAX_EDGES)) u_store (
		.clk(clk), .we(we), .waddr(total_q[IDXW-1:0]), .wdata(wdata),
		.raddr(iss_q[IDXW-1:0]), .rdata(rdata)
	);

	assign rd_src = rdata[RW-1 -: SRC_W];
	assign rd_dst = rdata[WEIGHT_BITS +: SRC_W];
	assign rd_w   = rdata[WEIGHT_BITS-1:0];

	// order key is (weight, arrival index); each pass finds the next key up
	assign gt_prev = !prev_any_q || (rd_w > prev_w_q) ||
	                 ((rd_w == prev_w_q) && (idx_s1 > prev_i_q));
	assign lt_best = !best_any_q || (rd_w < best_w_q);
	assign cand    = vld_s1 && gt_prev && lt_best;
	assign pass_done = (iss_q == total_q) && !vld_s1;
	assign best_in_range = (CW'(best_src_q) < CW'(vcnt)) && (CW'(best_dst_q) < CW'(vcnt));

	assign p_cur   = parent_q[cur_q];
	assign sum_val = ra_val_q + rb_val_q;
	assign need    = vcnt - 1'b1;

	assign join_go  = (st_q == ST_JOIN) && (!pend_v_q || !out_full);
	assign flush_go = (st_q == ST_FLUSH) && !out_full;

	always_comb begin
		out_push = 1'b0;
		out_data.tree_src    = pend_src_q;
		out_data.tree_dst    = pend_dst_q;
		out_data.tree_weight = WT_W'(pend_w_q);
		out_data.tree_valid  = 1'b1;
		out_data.tree_last   = 1'b0;
		if ((st_q == ST_JOIN) && (ra_q != rb_q) && pend_v_q) begin
			out_push = 1'b1;
		end else if (st_q == ST_FLUSH) begin
			out_push = 1'b1;
			out_data.tree_last = 1'b1;
			if (!pend_v_q) begin
				out_data.tree_src    = '0;
				out_data.tree_dst    = '0;
				out_data.tree_weight = '0;
				out_data.tree_valid  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_LOAD;
			total_q    <= '0;
			iss_q      <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			best_any_q <= 1'b0;
			prev_any_q <= 1'b0;
			best_w_q   <= '0;
			prev_w_q   <= '0;
			best_i_q   <= '0;
			prev_i_q   <= '0;
			best_src_q <= '0;
			best_dst_q <= '0;
			pend_v_q   <= 1'b0;
			pend_src_q <= '0;
			pend_dst_q <= '0;
			pend_w_q   <= '0;
			found_q    <= '0;
			cur_q      <= '0;
			ra_q       <= '0;
			rb_q       <= '0;
			ra_val_q   <= '0;
			rb_val_q   <= '0;
			for (int i = 0; i < MAX_VERTICES; i++) parent_q[i] <= '1;
		end else begin
			unique case (st_q)
				ST_LOAD: begin
					if (we) begin
						total_q <= total_q + 1'b1;
					end
					if (cmd_pop && cmd.item.edge_last) begin
						for (int i = 0; i < MAX_VERTICES; i++) parent_q[i] <= '1;
						found_q    <= '0;
						prev_any_q <= 1'b0;
						pend_v_q   <= 1'b0;
						best_any_q <= 1'b0;
						iss_q      <= '0;
						vld_s1     <= 1'b0;
						st_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (iss_q != total_q) begin
						iss_q  <= iss_q + 1'b1;
						vld_s1 <= 1'b1;
						idx_s1 <= iss_q[IDXW-1:0];
					end else begin
						vld_s1 <= 1'b0;
					end
					if (cand) begin
						best_any_q <= 1'b1;
						best_w_q   <= rd_w;
						best_i_q   <= idx_s1;
						best_src_q <= rd_src;
						best_dst_q <= rd_dst;
					end
					if (pass_done) begin
						if (!best_any_q) begin
							st_q <= ST_FLUSH;
						end else begin
							prev_any_q <= 1'b1;
							prev_w_q   <= best_w_q;
							prev_i_q   <= best_i_q;
							if (best_in_range) begin
								cur_q <= VW'(best_src_q);
								st_q  <= ST_FINDA;
							end else begin
								iss_q      <= '0;
								best_any_q <= 1'b0;
							end
						end
					end
				end
				ST_FINDA: begin
					if (p_cur[PW-1]) begin
						ra_q     <= cur_q;
						ra_val_q <= p_cur;
						cur_q    <= VW'(best_dst_q);
						st_q     <= ST_FINDB;
					end else begin
						cur_q <= p_cur[VW-1:0];
					end
				end
				ST_FINDB: begin
					if (p_cur[PW-1]) begin
						rb_q     <= cur_q;
						rb_val_q <= p_cur;
						st_q     <= ST_JOIN;
					end else begin
						cur_q <= p_cur[VW-1:0];
					end
				end
				ST_JOIN: begin
					if (ra_q == rb_q) begin
						iss_q      <= '0;
						best_any_q <= 1'b0;
						st_q       <= ST_SCAN;
					end else if (join_go) begin
						pend_v_q   <= 1'b1;
						pend_src_q <= best_src_q;
						pend_dst_q <= best_dst_q;
						pend_w_q   <= best_w_q;
						found_q    <= found_q + 1'b1;
						// larger set (more negative) keeps the root; ties go to dst
						if ($signed(ra_val_q) < $signed(rb_val_q)) begin
							parent_q[ra_q] <= sum_val;
							parent_q[rb_q] <= PW'(ra_q);
						end else begin
							parent_q[rb_q] <= sum_val;
							parent_q[ra_q] <= PW'(rb_q);
						end
						if (found_q + 1'b1 == need) begin
							st_q <= ST_FLUSH;
						end else begin
							iss_q      <= '0;
							best_any_q <= 1'b0;
							st_q       <= ST_SCAN;
						end
					end
				end
				ST_FLUSH: begin
					if (flush_go) begin
						total_q  <= '0;
						pend_v_q <= 1'b0;
						st_q     <= ST_LOAD;
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	a_found_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_LOAD) |-> (found_q <= need))
		else $error("tree edge count passed vertex_count-1");

	a_push_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (st_q == ST_JOIN || st_q == ST_FLUSH))
		else $error("result pushed outside join or flush");

	a_scan_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_SCAN) |-> !vld_s1)
		else $error("scan read in flight outside a pass");

	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNTW'(MAX_EDGES))
		else $error("edge count beyond store depth");
endmodule

/* src/minimum_spanning_tree_kruskal_core.sv */
// Top level of the Kruskal minimum spanning tree core.
// Usage:
//  - Edges enter as a queue: an edge transfers when push is high and full is
//    low. Edges with an endpoint at or above vertex_count, and edges past the
//    store depth, are dropped. An edge with edge_last set closes the graph.
//  - The engine takes a queued edge whenever it is loading. After the last edge
//    it runs passes over the edge store: each pass reads every stored edge
//    through the store's single read port and picks the next lightest one,
//    ties going to the earlier edge; a chosen edge then walks its two roots in
//    the parent table, one level per cycle, and joins them if they differ.
//  - Results leave as a queue: the oldest result is shown while empty is low
//    and transfers when pop is high. Tree edges come out in the order found;
//    tree_last marks the final one; a graph with no tree edge yields a single
//    result with tree_valid low. A stalled receiver backs up the result queue
//    and holds the engine; incoming edges queue up and then assert full.
//  - cfg_we writes vertex_count (reset 32), to be done only while idle.
//  - Reset clears counters, the parent table and both queues at once.
module minimum_spanning_tree_kruskal_core
	import mstk_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = 32,
	parameter int unsigned MAX_EDGES    = 256,
	parameter int unsigned WEIGHT_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  edge_t             edge_item,
	output logic              empty,
	input  logic              pop,
	output tree_t             tree_item,
	input  logic              cfg_we,
	input  logic [VCFG_W-1:0] cfg_data
);
	localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned CW  = VCW + VCFG_W;

	logic [VCFG_W-1:0] vcfg_q;
	logic [VCW-1:0]    vcnt;
	cmd_t              cmd;
	logic              cmd_valid, cmd_pop;
	logic              out_push, out_full;
	tree_t             out_data;
	logic [$bits(tree_t)-1:0] out_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcfg_q <= VCFG_RESET;
		end else if (cfg_we) begin
			vcfg_q <= cfg_data;
		end
	end

	// clamp the vertex count into 2..MAX_VERTICES
	always_comb begin
		if (CW'(vcfg_q) < CW'(2)) begin
			vcnt = VCW'(2);
		end else if (CW'(vcfg_q) > CW'(MAX_VERTICES)) begin
			vcnt = VCW'(MAX_VERTICES);
		end else begin
			vcnt = VCW'(vcfg_q);
		end
	end

	mstk_front #(.VCW(VCW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.push(push), .edge_item(edge_item), .full(full),
		.vcnt(vcnt), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
	);

	mstk_back #(
		.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES),
		.WEIGHT_BITS(WEIGHT_BITS), .VCW(VCW)
	) u_back (
		.clk(clk), .arst_n(arst_n), .vcnt(vcnt),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
		.out_push(out_push), .out_data(out_data), .out_full(out_full)
	);

	// result queue parts the engine from the receiver
	mstk_fifo #(.WIDTH($bits(tree_t)), .DEPTH(2)) u_outq (
		.clk(clk), .arst_n(arst_n),
		.push(out_push), .wdata(out_data), .full(out_full),
		.pop(pop), .rdata(out_raw), .empty(empty)
	);

	assign tree_item = tree_t'(out_raw);
endmodule
